>>> src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define PRC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> src/prc_pkg.sv
`default_nettype none
package prc_pkg;

	localparam int SNIFF_SIZE = 32;
	localparam int MIN_BATCH  = 16;
	localparam int BUF_DEPTH  = (SNIFF_SIZE > MIN_BATCH) ? SNIFF_SIZE : MIN_BATCH;
	localparam int AW         = $clog2(BUF_DEPTH);
	localparam int CW         = $clog2(BUF_DEPTH + 1);
	localparam int MW         = CW + 7;

	// register indexes
	localparam logic REG_MAX_POS = 1'b0;
	localparam logic REG_THRESH  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_RANGE  = 2'd1;
	localparam logic [1:0] KIND_BULK   = 2'd2;

	localparam logic [62:0] POS_MAX = {63{1'b1}};
	localparam logic [62:0] MAX_POS_RESET = 63'h7FFFFFFE80000000;
	localparam logic [6:0]  THRESH_RESET  = 7'd10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [62:0] range_first;
		logic [62:0] range_end;
		logic [30:0] group_key;
		logic [31:0] group_low;
		logic        group_last;
		logic        final_result;
	} res_t;

	// one step of the run/group unit
	typedef struct packed {
		logic        en;
		logic        flush;
		logic        bulk;
		logic [63:0] pos;
	} step_t;

endpackage
`default_nettype wire

>>> src/prc_ifs.sv
`default_nettype none
interface prc_in_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] position;
	logic               batch_last;
	modport source (output valid, position, batch_last, input ready);
	modport sink (input valid, position, batch_last, output ready);
endinterface

interface prc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [62:0] range_first;
	logic [62:0] range_end;
	logic [30:0] group_key;
	logic [31:0] group_low;
	logic        group_last;
	logic        final_result;
	modport source (output valid, kind, range_first, range_end, group_key, group_low,
		group_last, final_result, input ready);
	modport sink (input valid, kind, range_first, range_end, group_key, group_low,
		group_last, final_result, output ready);
endinterface
`default_nettype wire

>>> src/prc_buf.sv
`default_nettype none
module prc_buf (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [prc_pkg::AW-1:0] wr_addr,
	input  wire logic [63:0]         wr_data,
	input  wire logic                rd_en,
	input  wire logic [prc_pkg::AW-1:0] rd_addr,
	output logic      [63:0]         rd_data
);
	import prc_pkg::*;

	logic [63:0] mem [BUF_DEPTH];

	// prefix store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> src/prc_proc.sv
`default_nettype none
module prc_proc (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [62:0]    max_pos,
	input  wire prc_pkg::step_t step,
	output logic                emit,
	output prc_pkg::res_t       res
);
	import prc_pkg::*;

	logic [62:0] run_first_q, run_last_q, pend_q;
	logic        run_open_q, pend_valid_q, pend_break_q;

	logic        pos_ok, adj, diff_key;
	logic [62:0] run_end;
	res_t        run_res, pend_res;

	assign pos_ok   = !step.pos[63] && (step.pos[62:0] <= max_pos);
	assign adj      = ({1'b0, run_last_q} + 64'd1) == step.pos;
	assign diff_key = pend_q[62:32] != step.pos[62:32];
	assign run_end  = (run_last_q == POS_MAX) ? POS_MAX : run_last_q + 63'd1;

	// candidate results
	always_comb begin
		run_res = '0;
		run_res.range_first = run_first_q;
		if (run_first_q == run_last_q) begin
			run_res.kind = KIND_SINGLE;
		end else begin
			run_res.kind      = KIND_RANGE;
			run_res.range_end = run_end;
		end
		pend_res = '0;
		pend_res.kind      = KIND_BULK;
		pend_res.group_key = pend_q[62:32];
		pend_res.group_low = pend_q[31:0];
	end

	// result selection
	always_comb begin
		emit = 1'b0;
		res  = run_res;
		if (step.en) begin
			if (step.bulk) begin
				res = pend_res;
				if (step.flush) begin
					emit = pend_valid_q;
					res.group_last = 1'b1;
				end else begin
					emit = pend_valid_q && pos_ok;
					res.group_last = pend_break_q || diff_key;
				end
			end else begin
				if (step.flush) begin
					emit = run_open_q;
				end else begin
					emit = run_open_q && pos_ok && !adj;
				end
			end
			res.final_result = step.flush;
		end
	end

	// run and group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_first_q  <= '0;
			run_last_q   <= '0;
			pend_q       <= '0;
			run_open_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_break_q <= 1'b0;
		end else if (step.en) begin
			if (step.flush) begin
				run_first_q  <= '0;
				run_last_q   <= '0;
				pend_q       <= '0;
				run_open_q   <= 1'b0;
				pend_valid_q <= 1'b0;
				pend_break_q <= 1'b0;
			end else if (step.bulk) begin
				if (!pos_ok) begin
					if (pend_valid_q) pend_break_q <= 1'b1;
				end else begin
					pend_q       <= step.pos[62:0];
					pend_valid_q <= 1'b1;
					pend_break_q <= 1'b0;
				end
			end else if (pos_ok) begin
				if (!run_open_q || !adj) begin
					run_first_q <= step.pos[62:0];
				end
				run_open_q <= 1'b1;
				run_last_q <= step.pos[62:0];
			end
		end
	end
endmodule
`default_nettype wire

>>> src/position_run_coalescer.sv
`default_nettype none
// Position run coalescer. A batch of positions is taken one item per cycle; its first
// BUF_DEPTH items (32) are stored in a prefix memory while the breaks between raw
// neighbours are counted. When the prefix fills or the batch ends the mode is chosen
// and the prefix is replayed from the memory item by item (read, then process),
// during which no item is accepted. Later items of the batch then pass at one per
// cycle as long as results are taken. After the last item of a batch a flush step
// closes the open run or key group; only that closing result carries final_result,
// and a batch with no valid position yields nothing.
module position_run_coalescer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_idx,
	input  wire logic [62:0] cfg_wdata,
	prc_in_if.sink     in_ch,
	prc_out_if.source  out_ch
);
	import prc_pkg::*;

	localparam logic [2:0] ST_SNIFF = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_PR    = 3'd2;
	localparam logic [2:0] ST_STRM  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]    state_q;
	logic [62:0]   max_pos_q;
	logic [6:0]    thresh_q;
	logic [CW-1:0] cnt_q, n_q, bc_q, rd_q;
	logic [63:0]   prev_q;
	logic          bulk_q, done_q;
	logic          out_valid_q;
	res_t          out_q;

	logic          can_step, acc, emit, is_bnd, pick_bulk, close_pfx;
	logic [CW-1:0] n_next, bc_next, sniff_n;
	logic [MW-1:0] lhs, rhs;
	logic [63:0]   rd_data;
	step_t         step;
	res_t          res;

	assign can_step = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_SNIFF) || (state_q == ST_STRM && can_step);
	assign acc = in_ch.valid && in_ch.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pos_q <= MAX_POS_RESET;
			thresh_q  <= THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_POS: max_pos_q <= cfg_wdata;
				REG_THRESH:  thresh_q  <= cfg_wdata[6:0];
				default:     ;
			endcase
		end
	end

	// density estimate and mode choice
	assign is_bnd  = (cnt_q != '0) && (cnt_q < CW'(SNIFF_SIZE))
		&& ((in_ch.position - prev_q) != 64'd1);
	assign bc_next = is_bnd ? bc_q + CW'(1) : bc_q;
	assign n_next  = cnt_q + CW'(1);
	assign sniff_n = (n_next < CW'(SNIFF_SIZE)) ? n_next : CW'(SNIFF_SIZE);
	assign lhs     = MW'(bc_next) * MW'(100);
	assign rhs     = MW'(sniff_n - CW'(1)) * MW'(thresh_q);
	assign pick_bulk = (n_next >= CW'(MIN_BATCH)) && (lhs > rhs);
	assign close_pfx = in_ch.batch_last || (n_next == CW'(BUF_DEPTH));

	prc_buf u_buf (
		.clk     (clk),
		.wr_en   (acc && state_q == ST_SNIFF),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (in_ch.position),
		.rd_en   (state_q == ST_RD),
		.rd_addr (rd_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// step into the run/group unit
	always_comb begin
		step = '0;
		step.bulk = bulk_q;
		case (state_q)
			ST_PR: begin
				step.en  = can_step;
				step.pos = rd_data;
			end
			ST_STRM: begin
				step.en  = acc;
				step.pos = in_ch.position;
			end
			ST_FLUSH: begin
				step.en    = can_step;
				step.flush = 1'b1;
			end
			default: ;
		endcase
	end

	prc_proc u_proc (
		.clk     (clk),
		.arst_n  (arst_n),
		.max_pos (max_pos_q),
		.step    (step),
		.emit    (emit),
		.res     (res)
	);

	// batch sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SNIFF;
			cnt_q   <= '0;
			n_q     <= '0;
			bc_q    <= '0;
			rd_q    <= '0;
			prev_q  <= '0;
			bulk_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_SNIFF: begin
					if (acc) begin
						prev_q <= in_ch.position;
						if (close_pfx) begin
							cnt_q   <= '0;
							bc_q    <= '0;
							n_q     <= n_next;
							rd_q    <= '0;
							bulk_q  <= pick_bulk;
							done_q  <= in_ch.batch_last;
							state_q <= ST_RD;
						end else begin
							cnt_q <= n_next;
							bc_q  <= bc_next;
						end
					end
				end
				ST_RD: state_q <= ST_PR;
				ST_PR: begin
					if (can_step) begin
						rd_q <= rd_q + CW'(1);
						if (rd_q + CW'(1) == n_q) begin
							state_q <= done_q ? ST_FLUSH : ST_STRM;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_STRM: begin
					if (acc && in_ch.batch_last) state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (can_step) begin
						bulk_q  <= 1'b0;
						state_q <= ST_SNIFF;
					end
				end
				default: state_q <= ST_SNIFF;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.en && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.en && emit) out_q <= res;
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = out_q.kind;
	assign out_ch.range_first  = out_q.range_first;
	assign out_ch.range_end    = out_q.range_end;
	assign out_ch.group_key    = out_q.group_key;
	assign out_ch.group_low    = out_q.group_low;
	assign out_ch.group_last   = out_q.group_last;
	assign out_ch.final_result = out_q.final_result;

	`include "assert_macros.svh"

	`PRC_NEVER(a_no_take_in_drain, (state_q == ST_RD || state_q == ST_PR) && in_ch.ready, "item taken during drain")
	`PRC_NEVER(a_no_overwrite, step.en && emit && out_valid_q && !out_ch.ready, "result overwritten")
	`PRC_ASSERT(a_rd_in_range, (state_q == ST_PR) |-> (rd_q < n_q), "drain address past prefix")
	`PRC_ASSERT(a_flush_ends, (state_q == ST_FLUSH && can_step) |=> (state_q == ST_SNIFF && cnt_q == '0), "flush did not restart batch")

endmodule
`default_nettype wire
